>>> design/bce_pkg.sv
`default_nettype none

package bce_pkg;

  // Configuration register indexes on the write port.
  typedef enum logic [2:0] {
    CFG_DIRECTION = 3'd0,
    CFG_PERIOD    = 3'd1,
    CFG_ROW0      = 3'd2,
    CFG_ROW1      = 3'd3,
    CFG_ROW2      = 3'd4,
    CFG_ROW3      = 3'd5,
    CFG_ROW4      = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 40;
  localparam int unsigned CharW    = 8;
  localparam int unsigned CoordW   = 3;
  localparam int unsigned PeriodW  = 5;
  localparam int unsigned SquareN  = 5;

  typedef logic [CfgDataW-1:0]             row_t;
  typedef logic [SquareN-1:0][CfgDataW-1:0] square_t;

  // Reset square: ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ, column 0 in the low byte.
  localparam row_t RowReset0 = 40'h45_44_43_42_41;
  localparam row_t RowReset1 = 40'h4B_49_48_47_46;
  localparam row_t RowReset2 = 40'h50_4F_4E_4D_4C;
  localparam row_t RowReset3 = 40'h55_54_53_52_51;
  localparam row_t RowReset4 = 40'h5A_59_58_57_56;

  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;
  localparam logic [CharW-1:0] CaseOffset = 8'h20;
  localparam logic [CharW-1:0] CharUpperJ = 8'h4A;
  localparam logic [CharW-1:0] CharUpperI = 8'h49;

  // Letter at (row, column) of the square. Coordinates are always 0..4.
  function automatic logic [CharW-1:0] letter_at(input square_t sq,
                                                 input logic [CoordW-1:0] r,
                                                 input logic [CoordW-1:0] c);
    row_t             row;
    logic [CharW-1:0] ch;
    case (r)
      3'd0:    row = sq[0];
      3'd1:    row = sq[1];
      3'd2:    row = sq[2];
      3'd3:    row = sq[3];
      default: row = sq[4];
    endcase
    case (c)
      3'd0:    ch = row[7:0];
      3'd1:    ch = row[15:8];
      3'd2:    ch = row[23:16];
      3'd3:    ch = row[31:24];
      default: ch = row[39:32];
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> design/bce_ram.sv
`default_nettype none

module bce_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/bce_locate.sv
`default_nettype none

// Folds the character to upper case, maps J to I and finds its first
// position in the square in row-major order.
module bce_locate (
  input  wire logic [bce_pkg::CharW-1:0]  char_i,
  input  wire bce_pkg::square_t           square_i,
  output logic                            hit_o,
  output logic      [bce_pkg::CoordW-1:0] row_o,
  output logic      [bce_pkg::CoordW-1:0] col_o
);

  logic [bce_pkg::CharW-1:0] ch;

  always_comb begin
    ch = char_i;
    if (ch >= bce_pkg::CharLowerA && ch <= bce_pkg::CharLowerZ) begin
      ch = ch - bce_pkg::CaseOffset;
    end
    if (ch == bce_pkg::CharUpperJ) begin
      ch = bce_pkg::CharUpperI;
    end
  end

  // Scan from the last cell down so that the earliest match wins.
  always_comb begin
    hit_o = 1'b0;
    row_o = '0;
    col_o = '0;
    for (int i = bce_pkg::SquareN - 1; i >= 0; i--) begin
      for (int j = bce_pkg::SquareN - 1; j >= 0; j--) begin
        if (square_i[i][8*j +: 8] == ch) begin
          hit_o = 1'b1;
          row_o = 3'(i);
          col_o = 3'(j);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/bifid_cipher_engine.sv
`default_nettype none

// Periodic Bifid cipher engine over a loaded 5x5 square.
// Input channel: one character per transaction (char_in_i, end_of_message_i),
// qualified by in_valid_i and held off by in_stall_o. Output channel: one
// cipher character per transaction with block_last_o and message_last_o,
// qualified by out_valid_o and held off by out_stall_i.
// A character not found in the square is dropped. A kept character is stored
// as its row and column. When the block reaches the period, or end of message
// is flagged on a non-empty block, the block is emitted and in_stall_o stays
// high until its last character has been loaded into the output register.
// Each emitted character passes through the states S_RA, S_RB and S_RC on
// the shared coordinate read port: S_RA reads the first coordinate, S_RB
// takes it and reads the second, and S_RC loads the output. A stalled output
// simply holds the sequencer in its load step; nothing is lost.
// Reset clears the fill count, the sequencer and the output valid, and
// restores direction encrypt, period 5 and the square ABCDE..VWXYZ.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, as the block has no guard for this.
module bifid_cipher_engine #(
  parameter int unsigned MAX_PERIOD = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [bce_pkg::CharW-1:0]        char_in_i,
  input  wire logic                             end_of_message_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [bce_pkg::CharW-1:0]        char_out_o,
  output logic                                  block_last_o,
  output logic                                  message_last_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [bce_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [bce_pkg::CfgDataW-1:0]     cfg_data_i
);

  // Rows and columns live in two stores indexed by character position.
  localparam int unsigned AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int unsigned CW = $clog2(MAX_PERIOD + 1);
  localparam int unsigned JW = $clog2(2 * MAX_PERIOD) + 1;
  localparam logic [CW-1:0] MaxC = CW'(MAX_PERIOD);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RA   = 4'b0010,
    S_RB   = 4'b0100,
    S_RC   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] k_q, k_d;
  logic          eom_q, eom_d;
  logic          dir_q;
  logic [bce_pkg::PeriodW-1:0] period_q;
  bce_pkg::square_t sq_q;
  logic [bce_pkg::CoordW-1:0] r_q, r_d;
  logic          rd_sel_q;

  logic                       out_valid_q, out_valid_d;
  logic [bce_pkg::CharW-1:0]  char_out_q, char_out_d;
  logic                       block_last_q, block_last_d;
  logic                       message_last_q, message_last_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= 1'b0;
      period_q <= 5'd5;
      sq_q     <= {bce_pkg::RowReset4, bce_pkg::RowReset3, bce_pkg::RowReset2,
                   bce_pkg::RowReset1, bce_pkg::RowReset0};
    end else if (cfg_we_i) begin
      case (bce_pkg::cfg_idx_e'(cfg_idx_i))
        bce_pkg::CFG_DIRECTION: dir_q    <= cfg_data_i[0];
        bce_pkg::CFG_PERIOD:    period_q <= cfg_data_i[bce_pkg::PeriodW-1:0];
        bce_pkg::CFG_ROW0:      sq_q[0]  <= cfg_data_i;
        bce_pkg::CFG_ROW1:      sq_q[1]  <= cfg_data_i;
        bce_pkg::CFG_ROW2:      sq_q[2]  <= cfg_data_i;
        bce_pkg::CFG_ROW3:      sq_q[3]  <= cfg_data_i;
        bce_pkg::CFG_ROW4:      sq_q[4]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Square lookup of the incoming character.
  logic                       hit;
  logic [bce_pkg::CoordW-1:0] hit_row, hit_col;

  bce_locate u_locate (
    .char_i   (char_in_i),
    .square_i (sq_q),
    .hit_o    (hit),
    .row_o    (hit_row),
    .col_o    (hit_col)
  );

  logic in_fire, keep, full, emit;
  logic [CW-1:0] fill_new, eff_period;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign keep       = hit && (fill_q < MaxC);
  assign fill_new   = fill_q + CW'(keep);

  // A period of zero acts as one, and any value above the maximum as the
  // maximum.
  always_comb begin
    if (period_q == '0) begin
      eff_period = CW'(1);
    end else if ({1'b0, period_q} > 6'(MAX_PERIOD)) begin
      eff_period = MaxC;
    end else begin
      eff_period = CW'(period_q);
    end
  end

  assign full = keep && (fill_new >= eff_period);
  assign emit = full || (end_of_message_i && (fill_new != '0));

  // Read address for the coordinate in the current phase. Phase 0 fetches the
  // row of the output letter, phase 1 its column.
  logic            phase, rd_sel;
  logic [JW-1:0]   j, kx, nx;
  logic [AW-1:0]   rd_addr;
  logic [bce_pkg::CoordW-1:0] row_rd, col_rd, coord;

  assign phase = (state_q == S_RB) || (state_q == S_RC);
  assign kx    = JW'(k_q);
  assign nx    = JW'(n_q);

  always_comb begin
    if (dir_q) begin
      // Decryption: rows are the first half of the interleaved sequence.
      j       = phase ? (nx + kx) : kx;
      rd_sel  = j[0];
      rd_addr = AW'(j >> 1);
    end else begin
      // Encryption: all rows, then all columns, read in pairs.
      j       = (kx << 1) + JW'(phase);
      rd_sel  = (j >= nx);
      rd_addr = rd_sel ? AW'(j - nx) : AW'(j);
    end
  end

  bce_ram #(.WIDTH(bce_pkg::CoordW), .DEPTH(MAX_PERIOD)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && keep),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (hit_row),
    .raddr_i (rd_addr),
    .rdata_o (row_rd)
  );

  bce_ram #(.WIDTH(bce_pkg::CoordW), .DEPTH(MAX_PERIOD)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && keep),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (hit_col),
    .raddr_i (rd_addr),
    .rdata_o (col_rd)
  );

  always_ff @(posedge clk_i) begin
    rd_sel_q <= rd_sel;
    r_q      <= r_d;
  end

  assign coord = rd_sel_q ? col_rd : row_rd;

  // Sequencer.
  logic out_free, last_k;

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_k   = (k_q == n_q - CW'(1));

  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    n_d            = n_q;
    k_d            = k_q;
    eom_d          = eom_q;
    r_d            = r_q;
    out_valid_d    = out_valid_q && out_stall_i;
    char_out_d     = char_out_q;
    block_last_d   = block_last_q;
    message_last_d = message_last_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (emit) begin
            n_d     = fill_new;
            k_d     = '0;
            eom_d   = end_of_message_i;
            fill_d  = '0;
            state_d = S_RA;
          end else begin
            fill_d = fill_new;
          end
        end
      end
      S_RA: begin
        state_d = S_RB;
      end
      S_RB: begin
        r_d     = coord;
        state_d = S_RC;
      end
      S_RC: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          char_out_d     = bce_pkg::letter_at(sq_q, r_q, coord);
          block_last_d   = last_k;
          message_last_d = last_k && eom_q;
          if (last_k) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = S_RA;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      eom_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      n_q         <= n_d;
      k_q         <= k_d;
      eom_q       <= eom_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_out_q     <= char_out_d;
    block_last_q   <= block_last_d;
    message_last_q <= message_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign char_out_o     = char_out_q;
  assign block_last_o   = block_last_q;
  assign message_last_o = message_last_q;

endmodule

`default_nettype wire

>>> design/bce_checker.sv
`default_nettype none

module bce_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [bce_pkg::CharW-1:0]    char_out_o,
  input wire logic                         block_last_o,
  input wire logic                         message_last_o
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_out_o)
      && $stable(block_last_o) && $stable(message_last_o))
    else $error("stalled output transaction changed");

  // The end of a message always closes a block.
  a_msg_closes_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!message_last_o || block_last_o))
    else $error("message_last without block_last");

  // Results are only produced while the input side is held off.
  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output appeared while the input was open");

  // The edge after a reset edge shows no result.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

endmodule

bind bifid_cipher_engine bce_checker u_bce_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .char_out_o     (char_out_o),
  .block_last_o   (block_last_o),
  .message_last_o (message_last_o)
);

`default_nettype wire
